// ===== hdl/nls_pkg.sv =====
package nls_pkg;

  localparam int TERM_LIMIT_DEFAULT    = 64;
  localparam int FRACTION_BITS_DEFAULT = 30;

  localparam int X_W   = 32;
  localparam int TOL_W = 17;
  localparam int LOG_W = 21;

  localparam int Q16_ONE = 65536;
  localparam int LOG_SAT = 786432;

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZDIV,
    ST_ZSQ,
    ST_TDIV,
    ST_TACC,
    ST_TCMP,
    ST_PMUL,
    ST_ROUND,
    ST_DONE
  } nls_state_t;

  typedef struct packed {
    logic signed [LOG_W-1:0] log_value;
    logic                    domain_error;
    logic                    term_limit_hit;
  } nls_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } nls_status_t;

endpackage

// ===== hdl/nls_addsub.sv =====
module nls_addsub import nls_pkg::*; #(
  parameter int WIDTH = 35
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic [WIDTH:0] full;

  // carry out set on subtract means no borrow, a >= b
  assign full  = {1'b0, a} + {1'b0, b ^ {WIDTH{sub}}} + {{WIDTH{1'b0}}, sub};
  assign sum   = full[WIDTH-1:0];
  assign carry = full[WIDTH];

endmodule

// ===== hdl/nls_core.sv =====
module nls_core import nls_pkg::*; #(
  parameter int TERM_LIMIT    = TERM_LIMIT_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [X_W-1:0]    x_value,
  input  logic [TOL_W-1:0]  tolerance,
  input  logic              take,
  output nls_status_t       status,
  output nls_result_t       result
);

  localparam int F   = FRACTION_BITS;
  localparam int UW  = (F + 4 > 35) ? F + 4 : 35;
  localparam int SW  = F + 3;
  localparam int CW  = $clog2(TERM_LIMIT + 1);
  localparam int NW  = $clog2(2 * TERM_LIMIT);
  localparam int STW = $clog2(F);
  localparam logic [UW-1:0] RND = (UW'(1) << (F - 16)) >> 1;

  nls_state_t state, state_next;

  logic [UW-1:0]  acc;
  logic [F-1:0]   shreg;
  logic [STW-1:0] cnt;
  logic [32:0]    den;
  logic [F-1:0]   power;
  logic [F-1:0]   z2;
  logic [F-1:0]   term;
  logic [SW-1:0]  sum;
  logic [NW-1:0]  n;
  logic [CW-1:0]  count;
  logic           neg;
  logic           cut;
  nls_result_t    res;

  logic [UW-1:0]  op_a;
  logic [UW-1:0]  op_b;
  logic           op_sub;
  logic [UW-1:0]  add_sum;
  logic           add_carry;

  logic           last_step;
  logic           limit_reached;
  logic [UW-1:0]  div_shift;
  logic [F-1:0]   qbit_shift;
  logic [UW-1:0]  mag_full;
  logic [LOG_W-1:0] mag;
  logic [32:0]    num;

  nls_addsub #(.WIDTH(UW)) u_addsub (
    .a     (op_a),
    .b     (op_b),
    .sub   (op_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  assign last_step     = (cnt == STW'(F - 1));
  assign limit_reached = (count >= CW'(TERM_LIMIT));
  assign div_shift     = {acc[UW-2:0], shreg[F-1]};
  assign qbit_shift    = {shreg[F-2:0], add_carry};
  assign num = (x_value < X_W'(Q16_ONE)) ? 33'(Q16_ONE) - 33'(x_value)
                                         : 33'(x_value) - 33'(Q16_ONE);

  assign mag_full = UW'(add_sum >> (F - 16));
  assign mag      = (mag_full > UW'(LOG_SAT)) ? LOG_W'(LOG_SAT) : mag_full[LOG_W-1:0];

  // operand select for the shared adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state)
      ST_ZDIV: begin
        op_a   = {acc[UW-2:0], 1'b0};
        op_b   = UW'(den);
        op_sub = 1'b1;
      end
      ST_ZSQ, ST_PMUL: begin
        op_a = acc;
        op_b = shreg[0] ? UW'(power) : '0;
      end
      ST_TDIV: begin
        op_a   = div_shift;
        op_b   = UW'(n);
        op_sub = 1'b1;
      end
      ST_TACC: begin
        op_a = UW'(sum);
        op_b = UW'(term);
      end
      ST_TCMP: begin
        op_a   = UW'(tolerance) << (F - 16);
        op_b   = UW'(term);
        op_sub = 1'b1;
      end
      ST_ROUND: begin
        op_a = UW'(sum) << 1;
        op_b = RND;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    status.busy = (state != ST_IDLE);
    status.done = (state == ST_DONE);
    unique case (state)
      ST_IDLE:  if (start) state_next = (x_value == '0) ? ST_DONE : ST_ZDIV;
      ST_ZDIV:  if (last_step) state_next = ST_ZSQ;
      ST_ZSQ:   if (last_step) state_next = ST_TDIV;
      ST_TDIV:  if (last_step) state_next = ST_TACC;
      ST_TACC:  state_next = ST_TCMP;
      ST_TCMP:  state_next = (add_carry || limit_reached) ? ST_ROUND : ST_PMUL;
      ST_PMUL:  if (last_step) state_next = ST_TDIV;
      ST_ROUND: state_next = ST_DONE;
      ST_DONE:  if (take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_ZDIV || state == ST_ZSQ || state == ST_TDIV ||
                 state == ST_PMUL) begin
      cnt <= last_step ? '0 : cnt + STW'(1);
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          neg   <= (x_value < X_W'(Q16_ONE));
          acc   <= UW'(num);
          den   <= 33'(x_value) + 33'(Q16_ONE);
          shreg <= '0;
          sum   <= '0;
          n     <= NW'(1);
          count <= CW'(1);
          cut   <= 1'b0;
          res.log_value      <= '0;
          res.domain_error   <= 1'b1;
          res.term_limit_hit <= 1'b0;
        end
      end
      ST_ZDIV: begin
        shreg <= qbit_shift;
        if (last_step) begin
          // z magnitude becomes the first power and the squaring multiplier
          power <= qbit_shift;
          acc   <= '0;
        end else begin
          acc   <= add_carry ? add_sum : {acc[UW-2:0], 1'b0};
        end
      end
      ST_ZSQ: begin
        if (last_step) begin
          z2    <= F'(add_sum >> 1);
          acc   <= '0;
          shreg <= power;
        end else begin
          acc   <= UW'(add_sum >> 1);
          shreg <= shreg >> 1;
        end
      end
      ST_TDIV: begin
        acc   <= add_carry ? add_sum : div_shift;
        shreg <= qbit_shift;
        if (last_step) term <= qbit_shift;
      end
      ST_TACC: begin
        sum <= add_sum[SW-1:0];
      end
      ST_TCMP: begin
        if (!add_carry) begin
          if (limit_reached) begin
            cut <= 1'b1;
          end else begin
            acc   <= '0;
            shreg <= z2;
            n     <= n + NW'(2);
            count <= count + CW'(1);
          end
        end
      end
      ST_PMUL: begin
        if (last_step) begin
          power <= F'(add_sum >> 1);
          acc   <= '0;
          shreg <= F'(add_sum >> 1);
        end else begin
          acc   <= UW'(add_sum >> 1);
          shreg <= shreg >> 1;
        end
      end
      ST_ROUND: begin
        res.log_value      <= neg ? $signed(~mag + LOG_W'(1)) : $signed(mag);
        res.domain_error   <= 1'b0;
        res.term_limit_hit <= cut;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign result = res;

endmodule

// ===== hdl/natural_log_series.sv =====
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------
// input    | in_valid/in_stall  | x_value (unsigned Q16.16)
// output   | out_valid/out_stall| log_value (signed Q5.16), domain_error,
//          |                    | term_limit_hit
// config   | cfg_wr_en          | cfg_wr_data -> stop_tolerance
//
// one item at a time through a shared adder/subtractor stepped by the sequencer
// from the input transfer: the ratio divide and z squaring, then for each term a divide
// by n, a sum and a compare, with a multiply before each later term, then rounding and
// done before idle again; a zero argument goes straight to done and back to idle
// rst is synchronous: clears the sequencer and the output valid, tolerance back to 66
// in_stall is high from the input transfer until its result is loaded; a result waiting
// on out_stall holds the next finished item in the sequencer, which blocks accepting one
module natural_log_series import nls_pkg::*; #(
  parameter int TERM_LIMIT    = TERM_LIMIT_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [X_W-1:0]          x_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [LOG_W-1:0] log_value,
  output logic                    domain_error,
  output logic                    term_limit_hit,
  input  logic                    cfg_wr_en,
  input  logic [TOL_W-1:0]        cfg_wr_data
);

  logic [TOL_W-1:0] stop_tolerance;
  nls_status_t      status;
  nls_result_t      result;
  logic             start;
  logic             load;

  assign in_stall = status.busy;
  assign start    = in_valid && !status.busy;
  assign load     = status.done && (!out_valid || !out_stall);

  nls_core #(
    .TERM_LIMIT    (TERM_LIMIT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .x_value   (x_value),
    .tolerance (stop_tolerance),
    .take      (load),
    .status    (status),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_tolerance <= TOL_RESET;
    end else if (cfg_wr_en) begin
      stop_tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      log_value      <= result.log_value;
      domain_error   <= result.domain_error;
      term_limit_hit <= result.term_limit_hit;
    end
  end

endmodule

// ===== hdl/nls_checker.sv =====
module nls_checker import nls_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [LOG_W-1:0] log_value,
  input logic                    domain_error,
  input logic                    term_limit_hit
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(log_value) &&
      $stable(domain_error) && $stable(term_limit_hit))
    else $error("output changed while stalled");

  // block is busy right after taking an item
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken without going busy");

  a_domain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && domain_error |-> log_value == 0 && !term_limit_hit)
    else $error("domain error with nonzero result or limit flag");

  a_saturation: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(log_value) <= 786432 && $signed(log_value) >= -786432)
    else $error("log value outside saturation range");

endmodule

bind natural_log_series nls_checker u_nls_checker (.*);

// ===== dv/natural_log_series_tb.sv =====
module natural_log_series_tb;
  import nls_pkg::*;

  localparam int FB = FRACTION_BITS_DEFAULT;
  localparam int TL = TERM_LIMIT_DEFAULT;
  localparam int HOLD_CYCLES = 1500;
  localparam int RUN_LIMIT = 60_000_000;

  typedef struct {
    logic [X_W-1:0] x;
    nls_result_t    r;
  } log_expect_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [X_W-1:0]          x_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [LOG_W-1:0] log_value;
  logic                    domain_error;
  logic                    term_limit_hit;
  logic                    cfg_wr_en;
  logic [TOL_W-1:0]        cfg_wr_data;

  log_expect_t      pending_logs[$];
  logic [TOL_W-1:0] tol_model;
  logic             steady;
  int               hold_pending;
  int               mismatches;
  int               args_sent;
  int               results_seen;
  int               cut_seen;
  int               zero_seen;
  int               tol_settings;

  natural_log_series dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .x_value        (x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .log_value      (log_value),
    .domain_error   (domain_error),
    .term_limit_hit (term_limit_hit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ln(x) = 2 * sum of z^n / n over odd n, z = (x - 1) / (x + 1), sign and magnitude
  function automatic nls_result_t atanh_log(logic [X_W-1:0] x, logic [TOL_W-1:0] tol);
    nls_result_t  r;
    logic [63:0]  xw, num, den, zmag, z2, pw, term, sum, tol_fix, mag;
    logic [127:0] prod;
    logic         neg, cut, stop;
    int           k;
    r = '0;
    if (x == '0) begin
      r.domain_error = 1'b1;
      return r;
    end
    xw = 64'(x);
    neg = xw < 64'(Q16_ONE);
    num = neg ? 64'(Q16_ONE) - xw : xw - 64'(Q16_ONE);
    den = xw + 64'(Q16_ONE);
    zmag = (num << FB) / den;
    prod = 128'(zmag) * 128'(zmag);
    z2 = 64'(prod >> FB);
    pw = zmag;
    tol_fix = 64'(tol) << (FB - 16);
    sum = '0;
    cut = 1'b0;
    stop = 1'b0;
    for (k = 1; k <= TL && !stop; k++) begin
      term = pw / 64'(2 * k - 1);
      sum = sum + term;
      if (term <= tol_fix) begin
        stop = 1'b1;
      end else if (k == TL) begin
        cut = 1'b1;
        stop = 1'b1;
      end else begin
        prod = 128'(pw) * 128'(z2);
        pw = 64'(prod >> FB);
      end
    end
    mag = sum << 1;
    if (FB > 16) mag = mag + (64'd1 << (FB - 17));
    mag = mag >> (FB - 16);
    if (mag > 64'(LOG_SAT)) mag = 64'(LOG_SAT);
    r.log_value = neg ? -$signed(mag[LOG_W-1:0]) : $signed(mag[LOG_W-1:0]);
    r.term_limit_hit = cut;
    return r;
  endfunction

  // almost half the arguments near one, which converge in a few terms; a quarter over the full range
  function automatic logic [X_W-1:0] pick_x();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 2) return '0;
    if (sel < 47) return $urandom_range(32'h0003_0000, 32'h0000_5000);
    if (sel < 60) return $urandom_range(32'h0000_5000, 32'h0000_0001);
    if (sel < 75) return $urandom_range(32'h0010_0000, 32'h0003_0000);
    return $urandom;
  endfunction

  // called and returns at a falling edge; valid is left high for the caller to reuse
  task automatic send_x(input logic [X_W-1:0] x);
    log_expect_t e;
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    x_value  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e.x = x;
    e.r = atanh_log(x, tol_model);
    pending_logs.push_back(e);
    args_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_model = v;
    tol_settings++;
  endtask

  task automatic test_reset_tolerance();
    logic [X_W-1:0] xs[$];
    xs = {32'h0000_0000, 32'h0000_0001, 32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001,
          32'h0000_8000, 32'h0002_0000, 32'h0002_B7E1, 32'h0010_0000, 32'h8000_0000,
          32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (xs[i]) send_x(xs[i]);
    settle();
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(17'd1);
    send_x(32'h0000_8000);
    send_x(32'h0002_0000);
    send_x(32'h0000_C000);
    settle();
    // a term never exceeds a tolerance of one, so one term only
    write_tolerance(17'h1_0000);
    send_x(32'h0000_8000);
    send_x(32'h0004_0000);
    send_x(32'hFFFF_FFFF);
    settle();
    write_tolerance(17'h1_FFFF);
    send_x(32'h0002_0000);
    send_x(32'h0000_0001);
    settle();
    // zero tolerance: only a zero term ends the series early
    write_tolerance(17'd0);
    send_x(32'h0001_0000);
    send_x(32'h0001_8000);
    send_x(32'h0010_0000);
    settle();
  endtask

  task automatic test_backpressure();
    write_tolerance(TOL_RESET);
    hold_pending++;
    repeat (8) send_x($urandom_range(32'h0001_4000, 32'h0000_C000));
    settle();
  endtask

  task automatic test_random();
    for (int c = 0; c < 5; c++) begin
      case (c)
        0: write_tolerance(TOL_RESET);
        1: write_tolerance(TOL_W'($urandom_range(200, 1)));
        4: write_tolerance(TOL_W'($urandom_range(65536, 1)));
        default: write_tolerance(TOL_W'($urandom_range(4000, 1)));
      endcase
      for (int i = 0; i < 46; i++) begin
        steady = (c == 2) && (i < 40);
        send_x(pick_x());
      end
      steady = 1'b0;
      settle();
    end
  endtask

  // receiver side; a hold request is counted out here
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending != hold_served) begin
        hold_served = hold_pending;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk) begin : check_result
    log_expect_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_logs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: log %0d domain %0b cut %0b",
                   log_value, domain_error, term_limit_hit);
      end else begin
        e = pending_logs.pop_front();
        results_seen++;
        if (e.r.term_limit_hit) cut_seen++;
        if (e.r.domain_error) zero_seen++;
        if (log_value !== e.r.log_value || domain_error !== e.r.domain_error ||
            term_limit_hit !== e.r.term_limit_hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("x=%h tol=%0d: log %0d/%0d domain %0b/%0b cut %0b/%0b (exp/got)",
                     e.x, tol_model, e.r.log_value, log_value, e.r.domain_error,
                     domain_error, e.r.term_limit_hit, term_limit_hit);
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", pending_logs.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    x_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    steady = 1'b0;
    hold_pending = 0;
    mismatches = 0;
    args_sent = 0;
    results_seen = 0;
    cut_seen = 0;
    zero_seen = 0;
    tol_settings = 0;
    tol_model = TOL_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_tolerance();
    test_tolerance_extremes();
    test_backpressure();
    test_random();

    repeat (50) @(posedge clk);
    $display("%0d arguments under %0d tolerance settings, %0d results checked",
             args_sent, tol_settings + 1, results_seen);
    $display("%0d cut at the term limit, %0d zero arguments, %0d mismatches",
             cut_seen, zero_seen, mismatches);
    if (mismatches == 0 && pending_logs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
